// ===== rtl/core/mrst_pkg.sv =====
// Package for the multiple-response-set tokenizer: phase codes, result kinds,
// the fixed-width line state and the result record. No dependencies.
package mrst_pkg;

	typedef enum logic [13:0] {
		PH_START    = 14'b00000000000001,
		PH_NAME     = 14'b00000000000010,
		PH_TYPE     = 14'b00000000000100,
		PH_ESP      = 14'b00000000001000,
		PH_EFIRST   = 14'b00000000010000,
		PH_EMORE    = 14'b00000000100000,
		PH_VLEN0    = 14'b00000001000000,
		PH_VLEN     = 14'b00000010000000,
		PH_VBODY    = 14'b00000100000000,
		PH_PRELABEL = 14'b00001000000000,
		PH_LLEN0    = 14'b00010000000000,
		PH_LLEN     = 14'b00100000000000,
		PH_LBODY    = 14'b01000000000000,
		PH_VARS     = 14'b10000000000000
	} phase_t;

	typedef enum logic [2:0] {
		K_NAME   = 3'd0,
		K_VALUE  = 3'd1,
		K_LABEL  = 3'd2,
		K_VAR    = 3'd3,
		K_VAREND = 3'd4,
		K_SETEND = 3'd5,
		K_ERROR  = 3'd6
	} kind_t;

	localparam logic [1:0] SET_C = 2'd0;
	localparam logic [1:0] SET_D = 2'd1;
	localparam logic [1:0] SET_E = 2'd2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	localparam logic [13:0] FLAG_LIMIT = 14'd1000;
	localparam logic [13:0] FLAG_LABEL = 14'd11;
	localparam logic [31:0] NUM_NONE   = 32'hFFFF_FFFF;
	localparam logic [31:0] NUM_MAX    = 32'h7FFF_FFFF;

	typedef struct packed {
		phase_t      phase;
		logic [13:0] flag_acc;
		logic [1:0]  set_type;
		logic        label_src;
		logic [31:0] value_num;
		logic        digits_open;
		logic        in_var;
		logic        held_cr;
		logic        err;
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         content_byte;
		logic [1:0]         set_kind;
		logic               label_from_var;
		logic signed [31:0] counted_number;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase: PH_START, flag_acc: 14'd0, set_type: 2'd0, label_src: 1'b0,
		value_num: NUM_NONE, digits_open: 1'b0, in_var: 1'b0, held_cr: 1'b0,
		err: 1'b0
	};

	// back to line start, record-level flags kept
	function automatic state_t clear_line(state_t s);
		state_t r;
		r = s;
		r.phase       = PH_START;
		r.flag_acc    = '0;
		r.set_type    = '0;
		r.label_src   = 1'b0;
		r.value_num   = NUM_NONE;
		r.digits_open = 1'b0;
		r.in_var      = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/core/mrst_in_if.sv =====
// Byte channel of the tokenizer: valid/ready with one record byte per transaction.
// No dependencies.
interface mrst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, byte_value, last_byte, input ready);
	modport sink (input valid, byte_value, last_byte, output ready);
endinterface

// ===== rtl/core/mrst_out_if.sv =====
// Result channel of the tokenizer: valid/ready with one token result per transaction.
// No dependencies.
interface mrst_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [7:0]         content_byte;
	logic [1:0]         set_kind;
	logic               label_from_var;
	logic signed [31:0] counted_number;
	logic               last_of_run;

	modport source (output valid, kind, content_byte, set_kind, label_from_var,
		counted_number, last_of_run, input ready);
	modport sink (input valid, kind, content_byte, set_kind, label_from_var,
		counted_number, last_of_run, output ready);
endinterface

// ===== rtl/core/mrst_feed.sv =====
// One byte of line parsing: next line state and at most one result.
// Depends on mrst_pkg.
module mrst_feed
	import mrst_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  state_t                 st_in,
	input  logic [LENGTH_BITS-1:0] rem_in,
	input  logic [LENGTH_BITS-1:0] len_in,
	input  logic [7:0]             c,
	output state_t                 st_out,
	output logic [LENGTH_BITS-1:0] rem_out,
	output logic [LENGTH_BITS-1:0] len_out,
	output logic                   emit,
	output result_t                res,
	output logic                   err
);
	localparam int LW = LENGTH_BITS + 4;

	logic          dig;
	logic [3:0]    d;
	logic [LW-1:0] len_mul;
	logic [13:0]   flag_mul;
	logic [35:0]   val_mul;
	logic [31:0]   val_sat;

	assign dig = (c >= CH_0) && (c <= CH_9);
	assign d   = dig ? c[3:0] : 4'd0;

	// multiply by ten as shift-and-add
	assign len_mul  = {1'b0, len_in, 3'b000} + {3'b000, len_in, 1'b0} + LW'(d);
	assign flag_mul = {st_in.flag_acc[10:0], 3'b000} + {st_in.flag_acc[12:0], 1'b0}
		+ 14'(d);
	assign val_mul  = {1'b0, st_in.value_num, 3'b000} + {3'b000, st_in.value_num, 1'b0}
		+ 36'(d);
	assign val_sat  = (val_mul[35:31] != 5'd0) ? NUM_MAX : val_mul[31:0];

	always_comb begin
		st_out  = st_in;
		rem_out = rem_in;
		len_out = len_in;
		emit    = 1'b0;
		res     = '0;
		err     = 1'b0;
		unique case (st_in.phase)
			PH_START: begin
				if (c == CH_DOLLAR) begin
					emit = 1'b1;
					res.kind = K_NAME;
					res.content_byte = c;
					st_out.phase = PH_NAME;
				end else begin
					err = 1'b1;
				end
			end
			PH_NAME: begin
				priority if (c == CH_EQ) begin
					st_out.phase = PH_TYPE;
				end else if (c == CH_SP) begin
					err = 1'b1;
				end else begin
					emit = 1'b1;
					res.kind = K_NAME;
					res.content_byte = c;
				end
			end
			PH_TYPE: begin
				st_out.label_src   = 1'b0;
				st_out.value_num   = NUM_NONE;
				st_out.digits_open = 1'b0;
				priority if (c == CH_C) begin
					st_out.set_type = SET_C;
					st_out.phase = PH_PRELABEL;
				end else if (c == CH_D) begin
					st_out.set_type = SET_D;
					st_out.phase = PH_VLEN0;
				end else if (c == CH_E) begin
					st_out.set_type = SET_E;
					st_out.phase = PH_ESP;
				end else begin
					err = 1'b1;
				end
			end
			PH_ESP: begin
				if (c == CH_SP) st_out.phase = PH_EFIRST;
				else err = 1'b1;
			end
			PH_EFIRST: begin
				if (dig) begin
					st_out.flag_acc = 14'(d);
					st_out.phase = PH_EMORE;
				end else begin
					err = 1'b1;
				end
			end
			PH_EMORE: begin
				priority if (dig && (st_in.flag_acc < FLAG_LIMIT)) begin
					st_out.flag_acc = flag_mul;
				end else if (c == CH_SP) begin
					st_out.label_src = (st_in.flag_acc == FLAG_LABEL);
					st_out.phase = PH_VLEN0;
				end else begin
					err = 1'b1;
				end
			end
			PH_VLEN0, PH_LLEN0: begin
				if (dig) begin
					len_out = LENGTH_BITS'(d);
					st_out.phase = (st_in.phase == PH_VLEN0) ? PH_VLEN : PH_LLEN;
				end else begin
					err = 1'b1;
				end
			end
			PH_VLEN, PH_LLEN: begin
				priority if (dig) begin
					if (len_mul[LW-1:LENGTH_BITS] != 4'd0) err = 1'b1;
					else len_out = len_mul[LENGTH_BITS-1:0];
				end else if (c == CH_SP) begin
					rem_out = len_in;
					if (st_in.phase == PH_VLEN) begin
						st_out.digits_open = 1'b1;
						st_out.value_num = NUM_NONE;
						st_out.phase = (len_in != '0) ? PH_VBODY : PH_PRELABEL;
					end else begin
						st_out.in_var = 1'b0;
						st_out.phase = (len_in != '0) ? PH_LBODY : PH_VARS;
					end
				end else begin
					err = 1'b1;
				end
			end
			PH_VBODY: begin
				emit = 1'b1;
				res.kind = K_VALUE;
				res.content_byte = c;
				if (st_in.digits_open) begin
					priority if (!dig) st_out.digits_open = 1'b0;
					else if (st_in.value_num == NUM_NONE) st_out.value_num = 32'(d);
					else st_out.value_num = val_sat;
				end
				rem_out = rem_in - LENGTH_BITS'(1);
				if (rem_in == LENGTH_BITS'(1)) st_out.phase = PH_PRELABEL;
			end
			PH_PRELABEL: begin
				if (c == CH_SP) st_out.phase = PH_LLEN0;
				else err = 1'b1;
			end
			PH_LBODY: begin
				emit = 1'b1;
				res.kind = K_LABEL;
				res.content_byte = c;
				rem_out = rem_in - LENGTH_BITS'(1);
				if (rem_in == LENGTH_BITS'(1)) begin
					st_out.in_var = 1'b0;
					st_out.phase = PH_VARS;
				end
			end
			PH_VARS: begin
				if (c == CH_SP) begin
					if (st_in.in_var) begin
						emit = 1'b1;
						res.kind = K_VAREND;
						st_out.in_var = 1'b0;
					end
				end else begin
					emit = 1'b1;
					res.kind = K_VAR;
					res.content_byte = c;
					st_out.in_var = 1'b1;
				end
			end
			default: err = 1'b1;
		endcase
		if (err) begin
			emit = 1'b1;
			res = '0;
			res.kind = K_ERROR;
		end
	end
endmodule

// ===== rtl/core/mrst_step.sv =====
// Whole update for one record byte: held carriage return, the byte itself,
// line end and record end. Depends on mrst_pkg and mrst_feed.
module mrst_step
	import mrst_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  state_t                 st_q,
	input  logic [LENGTH_BITS-1:0] rem_q,
	input  logic [LENGTH_BITS-1:0] len_q,
	input  logic [7:0]             byte_value,
	input  logic                   last_byte,
	output state_t                 st_nx,
	output logic [LENGTH_BITS-1:0] rem_nx,
	output logic [LENGTH_BITS-1:0] len_nx,
	output result_t [3:0]          res,
	output logic [2:0]             res_cnt
);
	state_t                 st_a, st_b, st_sel;
	logic [LENGTH_BITS-1:0] rem_a, len_a, rem_b, len_b, rem_sel, len_sel;
	logic                   emit_a, emit_b, err_a, err_b;
	result_t                res_a, res_b;

	// the held carriage return is replayed ahead of the current byte
	mrst_feed #(.LENGTH_BITS(LENGTH_BITS)) u_feed_cr (
		.st_in(st_q), .rem_in(rem_q), .len_in(len_q), .c(CH_CR),
		.st_out(st_a), .rem_out(rem_a), .len_out(len_a),
		.emit(emit_a), .res(res_a), .err(err_a)
	);

	assign st_sel  = st_q.held_cr ? st_a : st_q;
	assign rem_sel = st_q.held_cr ? rem_a : rem_q;
	assign len_sel = st_q.held_cr ? len_a : len_q;

	mrst_feed #(.LENGTH_BITS(LENGTH_BITS)) u_feed_byte (
		.st_in(st_sel), .rem_in(rem_sel), .len_in(len_sel), .c(byte_value),
		.st_out(st_b), .rem_out(rem_b), .len_out(len_b),
		.emit(emit_b), .res(res_b), .err(err_b)
	);

	always_comb begin
		state_t                 s;
		logic [LENGTH_BITS-1:0] r, l;
		logic                   keep_held, line_end;
		logic [3:0]             v;
		result_t [3:0]          item;
		logic [2:0]             cnt;
		s         = st_q;
		r         = rem_q;
		l         = len_q;
		keep_held = 1'b0;
		line_end  = 1'b0;
		v         = '0;
		item      = '0;
		item[0]   = res_a;
		item[1]   = res_b;
		if (!st_q.err) begin
			if ((byte_value == CH_LF) || (byte_value == CH_NUL)) begin
				s.held_cr = 1'b0;
				line_end = 1'b1;
			end else begin
				if (st_q.held_cr) begin
					v[0] = emit_a;
					s = st_a;
					r = rem_a;
					l = len_a;
					s.held_cr = 1'b0;
					s.err = err_a;
				end
				if (!s.err) begin
					if (byte_value == CH_CR) begin
						s.held_cr = 1'b1;
					end else begin
						v[1] = emit_b;
						keep_held = s.held_cr;
						s = st_b;
						r = rem_b;
						l = len_b;
						s.held_cr = keep_held;
						s.err = err_b;
					end
				end
				if (last_byte && !s.err) begin
					s.held_cr = 1'b0;
					line_end = 1'b1;
				end
			end
			if (line_end) begin
				if (s.phase == PH_VARS) begin
					v[2] = s.in_var;
					item[2].kind = K_VAREND;
					v[3] = 1'b1;
					item[3].kind = K_SETEND;
					item[3].set_kind = s.set_type;
					item[3].label_from_var = s.label_src;
					item[3].counted_number = s.value_num;
				end else if (s.phase != PH_START) begin
					// line ended before the set was complete
					v[3] = 1'b1;
					item[3].kind = K_ERROR;
					s.err = 1'b1;
				end
				s = clear_line(s);
				r = '0;
				l = '0;
			end
		end
		if (last_byte) begin
			s = STATE_RESET;
			r = '0;
			l = '0;
		end
		res = '0;
		cnt = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (v[i]) begin
				res[cnt[1:0]] = item[i];
				cnt = cnt + 3'd1;
			end
		end
		st_nx   = s;
		rem_nx  = r;
		len_nx  = l;
		res_cnt = cnt;
	end
endmodule

// ===== rtl/core/mrst_outq.sv =====
// Result register: holds the results of one byte and hands them out one per
// transaction, oldest first. Depends on mrst_pkg.
module mrst_outq
	import mrst_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_req,
	input  result_t [3:0] load_res,
	input  logic [2:0]    load_cnt,
	input  logic          pop,
	output logic          can_load,
	output logic          head_valid,
	output logic          head_last,
	output result_t       head
);
	result_t [3:0] slot_q;
	logic [2:0]    cnt_q;
	logic          load;

	// refill in the cycle the final pending result leaves
	assign can_load   = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && pop);
	assign load       = load_req && can_load;
	assign head_valid = (cnt_q != 3'd0);
	assign head_last  = (cnt_q == 3'd1);
	assign head       = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_res;
		end else if (pop) begin
			for (int i = 0; i < 3; i++) slot_q[i] <= slot_q[i+1];
			slot_q[3] <= '0;
		end
	end
endmodule

// ===== rtl/core/multiple_response_set_tokenizer_top.sv =====
// Multiple-response-set tokenizer, top level. Depends on mrst_pkg, mrst_in_if,
// mrst_out_if, mrst_step, mrst_feed and mrst_outq.
// Throughput: one byte per cycle while each byte gives at most one result and the
// result channel takes every result; a byte with n results holds the result
// register for n output transactions.
// Reset clears all control state: line start, no held carriage return, no error.
module multiple_response_set_tokenizer_top
	import mrst_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	mrst_in_if.sink    byte_ch,
	mrst_out_if.source result_ch
);
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	state_t                 st_q, st_nx;
	logic [LENGTH_BITS-1:0] rem_q, len_q, rem_nx, len_nx;
	result_t [3:0]          step_res;
	logic [2:0]             step_cnt;
	logic                   can_load, adv, pop, head_valid, head_last;
	result_t                head;

	assign adv           = valid_s1 && can_load;
	assign byte_ch.ready = !valid_s1 || adv;
	assign pop           = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.byte_value;
			last_s1 <= byte_ch.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RESET;
			rem_q <= '0;
			len_q <= '0;
		end else if (adv) begin
			st_q  <= st_nx;
			rem_q <= rem_nx;
			len_q <= len_nx;
		end
	end

	mrst_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
		.st_q(st_q), .rem_q(rem_q), .len_q(len_q),
		.byte_value(byte_s1), .last_byte(last_s1),
		.st_nx(st_nx), .rem_nx(rem_nx), .len_nx(len_nx),
		.res(step_res), .res_cnt(step_cnt)
	);

	mrst_outq u_outq (
		.clk(clk), .arst_n(arst_n),
		.load_req(valid_s1), .load_res(step_res), .load_cnt(step_cnt),
		.pop(pop), .can_load(can_load),
		.head_valid(head_valid), .head_last(head_last), .head(head)
	);

	assign result_ch.valid          = head_valid;
	assign result_ch.kind           = head.kind;
	assign result_ch.content_byte   = head.content_byte;
	assign result_ch.set_kind       = head.set_kind;
	assign result_ch.label_from_var = head.label_from_var;
	assign result_ch.counted_number = head.counted_number;
	assign result_ch.last_of_run    = head_last;

	// bytes after an error give nothing until the record ends
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st_q.err && !last_s1 |-> step_cnt == 3'd0)
		else $error("byte after error produced results");

	// record end returns to line start with nothing held
	a_record_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q.phase == PH_START && !st_q.err && !st_q.held_cr)
		else $error("state not cleared at record end");

	// an error is always the final result of its byte
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.kind == K_ERROR |-> result_ch.last_of_run)
		else $error("error result not last of run");
endmodule

// ===== tb/multiple_response_set_tokenizer_top_tb.sv =====
// Self-checking bench for multiple_response_set_tokenizer_top: directed and random record
// text is pushed through the byte channel, every result is checked against a local tokenizer.
// Depends on mrst_pkg, mrst_in_if, mrst_out_if and the tokenizer RTL.
module multiple_response_set_tokenizer_top_tb;
	import mrst_pkg::*;

	localparam int LEN_BITS = 16;
	localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 1;
	localparam int SHOW_LIMIT = 10;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_TOKENS_PER_BYTE = 4;

	typedef struct {
		kind_t              kind;
		logic [7:0]         data;
		logic [1:0]         skind;
		logic               lfv;
		logic signed [31:0] num;
		logic               last;
	} token_t;

	logic clk;
	logic arst_n;

	mrst_in_if  byte_bus ();
	mrst_out_if result_bus ();

	multiple_response_set_tokenizer_top #(
		.LENGTH_BITS(LEN_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_bus),
		.result_ch(result_bus)
	);

	// line and record state of the local tokenizer
	phase_t                ln_phase;
	logic [LEN_BITS-1:0]   body_left;
	longint unsigned       len_acc;
	logic [13:0]           flag_acc;
	logic [1:0]            set_type;
	logic                  label_src;
	logic [31:0]           value_num;
	bit                    digits_open;
	bit                    in_var;
	bit                    held_cr;
	bit                    err_latched;

	token_t     step_tokens[$];
	token_t     expected_tokens[$];
	logic [7:0] rec_bytes[$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int live_bytes = 0;
	int mismatches = 0;
	bit long_hold = 1'b0;
	event hold_kick;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------- tokenizer
	function automatic void add_token(kind_t k, logic [7:0] c, logic [1:0] sk, logic lf,
			logic [31:0] n);
		token_t t;
		if (step_tokens.size() >= MAX_TOKENS_PER_BYTE)
			return;
		t.kind  = k;
		t.data  = c;
		t.skind = sk;
		t.lfv   = lf;
		t.num   = n;
		t.last  = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void raise_error();
		add_token(K_ERROR, 8'h00, 2'd0, 1'b0, 32'd0);
		err_latched = 1'b1;
	endfunction

	function automatic void restart_line();
		ln_phase    = PH_START;
		body_left   = '0;
		len_acc     = 0;
		flag_acc    = '0;
		set_type    = SET_C;
		label_src   = 1'b0;
		value_num   = NUM_NONE;
		digits_open = 1'b0;
		in_var      = 1'b0;
	endfunction

	function automatic void feed_byte(logic [7:0] c);
		bit dig;
		logic [3:0] d;
		longint unsigned wide;
		dig = (c >= CH_0) && (c <= CH_9);
		d = dig ? 4'(c - CH_0) : 4'd0;
		case (ln_phase)
			PH_START: begin
				if (c == CH_DOLLAR) begin
					add_token(K_NAME, c, 2'd0, 1'b0, 32'd0);
					ln_phase = PH_NAME;
				end else
					raise_error();
			end
			PH_NAME: begin
				if (c == CH_EQ)
					ln_phase = PH_TYPE;
				else if (c == CH_SP)
					raise_error();
				else
					add_token(K_NAME, c, 2'd0, 1'b0, 32'd0);
			end
			PH_TYPE: begin
				label_src   = 1'b0;
				value_num   = NUM_NONE;
				digits_open = 1'b0;
				if (c == CH_C) begin
					set_type = SET_C;
					ln_phase = PH_PRELABEL;
				end else if (c == CH_D) begin
					set_type = SET_D;
					ln_phase = PH_VLEN0;
				end else if (c == CH_E) begin
					set_type = SET_E;
					ln_phase = PH_ESP;
				end else
					raise_error();
			end
			PH_ESP: begin
				if (c == CH_SP)
					ln_phase = PH_EFIRST;
				else
					raise_error();
			end
			PH_EFIRST: begin
				if (dig) begin
					flag_acc = 14'(d);
					ln_phase = PH_EMORE;
				end else
					raise_error();
			end
			PH_EMORE: begin
				if (dig && flag_acc < FLAG_LIMIT)
					flag_acc = flag_acc * 14'd10 + 14'(d);
				else if (c == CH_SP) begin
					label_src = (flag_acc == FLAG_LABEL);
					ln_phase  = PH_VLEN0;
				end else
					raise_error();
			end
			PH_VLEN0, PH_LLEN0: begin
				if (!dig)
					raise_error();
				else begin
					len_acc  = 64'(d);
					ln_phase = (ln_phase == PH_VLEN0) ? PH_VLEN : PH_LLEN;
				end
			end
			PH_VLEN, PH_LLEN: begin
				if (dig) begin
					len_acc = len_acc * 10 + 64'(d);
					if (len_acc > LEN_MAX)
						raise_error();
				end else if (c == CH_SP) begin
					body_left = len_acc[LEN_BITS-1:0];
					if (ln_phase == PH_VLEN) begin
						digits_open = 1'b1;
						value_num   = NUM_NONE;
						ln_phase    = (body_left != 0) ? PH_VBODY : PH_PRELABEL;
					end else begin
						in_var   = 1'b0;
						ln_phase = (body_left != 0) ? PH_LBODY : PH_VARS;
					end
				end else
					raise_error();
			end
			PH_VBODY: begin
				add_token(K_VALUE, c, 2'd0, 1'b0, 32'd0);
				if (digits_open) begin
					if (!dig)
						digits_open = 1'b0;
					else if (value_num == NUM_NONE)
						value_num = 32'(d);
					else begin
						// saturates at the largest positive count
						wide = 64'(value_num) * 10 + 64'(d);
						value_num = (wide > NUM_MAX) ? NUM_MAX : wide[31:0];
					end
				end
				body_left = body_left - LEN_BITS'(1);
				if (body_left == 0)
					ln_phase = PH_PRELABEL;
			end
			PH_PRELABEL: begin
				if (c == CH_SP)
					ln_phase = PH_LLEN0;
				else
					raise_error();
			end
			PH_LBODY: begin
				add_token(K_LABEL, c, 2'd0, 1'b0, 32'd0);
				body_left = body_left - LEN_BITS'(1);
				if (body_left == 0) begin
					in_var   = 1'b0;
					ln_phase = PH_VARS;
				end
			end
			PH_VARS: begin
				if (c == CH_SP) begin
					if (in_var) begin
						add_token(K_VAREND, 8'h00, 2'd0, 1'b0, 32'd0);
						in_var = 1'b0;
					end
				end else begin
					add_token(K_VAR, c, 2'd0, 1'b0, 32'd0);
					in_var = 1'b1;
				end
			end
			default: raise_error();
		endcase
	endfunction

	function automatic void close_line();
		if (ln_phase == PH_VARS) begin
			if (in_var)
				add_token(K_VAREND, 8'h00, 2'd0, 1'b0, 32'd0);
			add_token(K_SETEND, 8'h00, set_type, label_src, value_num);
		end else if (ln_phase != PH_START)
			raise_error();
		restart_line();
	endfunction

	// returns 1 when the byte was not swallowed by a latched error
	function automatic bit tokenize_byte(logic [7:0] b, bit last);
		bit live;
		live = !err_latched;
		step_tokens.delete();
		if (live) begin
			if (b == CH_LF || b == CH_NUL) begin
				held_cr = 1'b0;
				close_line();
			end else begin
				// a held carriage return turns out to be content
				if (held_cr) begin
					held_cr = 1'b0;
					feed_byte(CH_CR);
				end
				if (!err_latched) begin
					if (b == CH_CR)
						held_cr = 1'b1;
					else
						feed_byte(b);
				end
				if (last && !err_latched) begin
					held_cr = 1'b0;
					close_line();
				end
			end
		end
		if (last) begin
			restart_line();
			held_cr     = 1'b0;
			err_latched = 1'b0;
		end
		if (step_tokens.size() != 0)
			step_tokens[step_tokens.size()-1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
		return live;
	endfunction

	// ---------------------------------------------------------------- channels
	task automatic push_byte(input logic [7:0] b, input bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
		byte_bus.valid      <= 1'b1;
		byte_bus.byte_value <= b;
		byte_bus.last_byte  <= last;
		do
			@(negedge clk);
		while (byte_bus.ready !== 1'b1);
		// transaction happens at the coming rising edge
		if (tokenize_byte(b, last))
			live_bytes++;
		@(posedge clk);
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], last_at_end && (i == s.len() - 1));
	endtask

	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_bus.ready <= !long_hold && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		forever begin
			@(hold_kick);
			@(negedge clk);
			long_hold = 1'b1;
			repeat (LONG_HOLD_CYCLES) @(negedge clk);
			long_hold = 1'b0;
		end
	end

	function automatic void note_fault(string what, token_t e);
		mismatches++;
		if (mismatches <= SHOW_LIMIT) begin
			$display("%s: exp kind %0d byte %h set %0d lfv %0d num %0d last %0d",
				what, e.kind, e.data, e.skind, e.lfv, e.num, e.last);
			$display("    got kind %0d byte %h set %0d lfv %0d num %0d last %0d",
				result_bus.kind, result_bus.content_byte, result_bus.set_kind,
				result_bus.label_from_var, result_bus.counted_number, result_bus.last_of_run);
		end
	endfunction

	always @(negedge clk) begin
		token_t e;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (expected_tokens.size() == 0) begin
				e = '{K_ERROR, 8'h00, 2'd0, 1'b0, 32'sd0, 1'b0};
				note_fault("unexpected result", e);
			end else begin
				e = expected_tokens.pop_front();
				if (result_bus.kind !== e.kind || result_bus.content_byte !== e.data ||
						result_bus.set_kind !== e.skind || result_bus.label_from_var !== e.lfv ||
						result_bus.counted_number !== e.num || result_bus.last_of_run !== e.last)
					note_fault("mismatch", e);
			end
		end
	end

	// ---------------------------------------------------------------- record text
	function automatic void put(logic [7:0] b);
		rec_bytes.push_back(b);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == CH_LF || b == CH_SP || b == CH_EQ);
		return b;
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == CH_LF);
		return b;
	endfunction

	function automatic void put_number(int unsigned v);
		logic [7:0] digs[$];
		do begin
			digs.push_front(8'(CH_0 + v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[i])
			put(digs[i]);
	endfunction

	function automatic void put_length(int unsigned v);
		if ($urandom_range(9) == 0)
			put(CH_0);
		put_number(v);
	endfunction

	function automatic void put_value();
		bit all_digits;
		int unsigned n;
		all_digits = ($urandom_range(7) == 0);
		n = all_digits ? 11 : $urandom_range(0, 5);
		put_length(n);
		put(CH_SP);
		repeat (n) begin
			if (all_digits || $urandom_range(3) != 0)
				put(8'(CH_0 + $urandom_range(9)));
			else
				put(body_byte());
		end
	endfunction

	function automatic void put_set_line();
		int unsigned m;
		put(CH_DOLLAR);
		repeat ($urandom_range(0, 3)) put(text_byte());
		put(CH_EQ);
		case ($urandom_range(2))
			0: put(CH_C);
			1: begin
				put(CH_D);
				put_value();
			end
			default: begin
				put(CH_E);
				put(CH_SP);
				if ($urandom_range(2) == 0)
					put_number(32'(FLAG_LABEL));
				else
					put_number($urandom_range(0, 1000));
				put(CH_SP);
				put_value();
			end
		endcase
		put(CH_SP);
		m = $urandom_range(0, 4);
		put_length(m);
		put(CH_SP);
		repeat (m) put(body_byte());
		repeat ($urandom_range(0, 3)) begin
			repeat ($urandom_range(1, 2)) put(CH_SP);
			repeat ($urandom_range(1, 4)) put(text_byte());
		end
		if ($urandom_range(3) == 0)
			put(CH_SP);
	endfunction

	function automatic void break_line(int start);
		int pos;
		pos = $urandom_range(start, rec_bytes.size() - 1);
		case ($urandom_range(2))
			0: while (rec_bytes.size() > pos + 1) void'(rec_bytes.pop_back());
			1: rec_bytes[pos] = 8'($urandom_range(0, 255));
			default: repeat (5) rec_bytes.insert(pos, CH_9);
		endcase
	endfunction

	function automatic void build_record(int broken_pct);
		int lines;
		int start;
		rec_bytes.delete();
		if (broken_pct != 0 && $urandom_range(19) == 0) begin
			repeat ($urandom_range(1, 30)) put(8'($urandom_range(0, 255)));
			return;
		end
		lines = $urandom_range(1, 3);
		for (int i = 0; i < lines; i++) begin
			if ($urandom_range(9) == 0)
				put(CH_LF);
			start = rec_bytes.size();
			put_set_line();
			if ($urandom_range(99) < broken_pct)
				break_line(start);
			case ($urandom_range(4))
				0: put(CH_LF);
				1: begin
					put(CH_CR);
					put(CH_LF);
				end
				2: put(CH_NUL);
				3: put(CH_CR);
				default: ;
			endcase
		end
	endfunction

	task automatic send_records(input int target, input int broken_pct);
		int goal;
		goal = live_bytes + target;
		while (live_bytes < goal) begin
			build_record(broken_pct);
			foreach (rec_bytes[i])
				push_byte(rec_bytes[i], i == rec_bytes.size() - 1);
		end
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_category_set();
		// top-bit name byte, variable closed by the record end
		send_text("$\377=C 0 v", 1'b1);
	endtask

	task automatic test_dichotomy_set();
		send_text("$d=D2 07 1 L  a b \r\n", 1'b1);
	endtask

	task automatic test_e_flag_label();
		// flag eleven, empty value, NUL ends the line, lone CR dropped at record end
		send_text("$e=E 11 0  0 x", 1'b0);
		push_byte(CH_NUL, 1'b0);
		send_text("\r", 1'b1);
	endtask

	task automatic test_value_saturation();
		send_text("$s=D12 999999999999 0 ", 1'b1);
	endtask

	task automatic test_malformed_lines();
		send_text("$a b\nq", 1'b1);
		send_text("$=E 10000 1 x", 1'b1);
		send_text("$=D65536 ", 1'b1);
		send_text("x", 1'b1);
		send_text("$=C 1", 1'b1);
		send_text("$=E 1\rx", 1'b1);
	endtask

	task automatic test_random_traffic();
		src_idle_pct = 30;
		snk_idle_pct = 62;
		send_records(100, 20);
		src_idle_pct = 62;
		snk_idle_pct = 30;
		send_records(100, 20);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_records(100, 20);
	endtask

	task automatic test_backpressure();
		// receiver parked while the sender keeps offering well-formed records
		src_idle_pct = 0;
		snk_idle_pct = 0;
		-> hold_kick;
		send_records(100, 0);
	endtask

	initial begin
		arst_n              = 1'b0;
		byte_bus.valid      = 1'b0;
		byte_bus.byte_value = 8'h00;
		byte_bus.last_byte  = 1'b0;
		restart_line();
		held_cr     = 1'b0;
		err_latched = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 30;
		snk_idle_pct = 62;
		test_category_set();
		test_dichotomy_set();
		test_e_flag_label();
		test_value_saturation();
		test_malformed_lines();
		test_random_traffic();
		test_backpressure();
		byte_bus.valid <= 1'b0;

		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
